// ===== src/ngls_pkg.sv =====
// Shared constants, codes and types of the n-gram log-probability scorer.
package ngls_pkg;

    // Default sizing of the scorer
    localparam int NGLS_MAX_WINDOW    = 3;
    localparam int NGLS_ALPHABET_SIZE = 26;
    localparam int NGLS_LOG_WIDTH     = 16;
    localparam int NGLS_SUM_WIDTH     = 32;

    // Fixed port field widths
    localparam int LETTER_PORT_W = 5;
    localparam int INDEX_PORT_W  = 15;
    localparam int LOG_PORT_W    = 16;
    localparam int SCORE_W       = 32;
    localparam int S_TDATA_W     = 40;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int NGRAM_LEN_W   = 2;

    // Item kinds carried on s_tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LETTER = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NGRAM_LENGTH     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MISSING_LOG_PROB = 1'd1;

    // Control travelling with a letter from the window stage to the sum stage
    typedef struct packed {
        logic valid;
        logic score;
        logic last;
    } ngls_s2_ctrl_t;

endpackage

// ===== src/ngls_table.sv =====
// Log-probability table with present marks: one port, registered read data.
module ngls_table #(
    parameter int DEPTH  = 17576,
    parameter int ADDR_W = 15,
    parameter int DATA_W = 17
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ngls_window.sv =====
// Letter history and window address of the scorer.
module ngls_window #(
    parameter int MAX_WINDOW    = 3,
    parameter int ALPHABET_SIZE = 26,
    parameter int ADDR_W        = 15
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 advance,
    input  logic [ngls_pkg::LETTER_PORT_W-1:0]   letter,
    input  logic                                 end_of_text,
    input  logic [ngls_pkg::NGRAM_LEN_W-1:0]     ngram_length,
    output logic [ADDR_W-1:0]                    win_addr,
    output logic                                 win_score
);
    import ngls_pkg::*;

    localparam int LETTER_W = $clog2(ALPHABET_SIZE);
    localparam int HIST_D   = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
    localparam int NW_W     = $clog2(MAX_WINDOW + 1);
    localparam logic [ADDR_W-1:0] RADIX = ADDR_W'(ALPHABET_SIZE);

    logic [LETTER_W-1:0] hist_reg [HIST_D];
    logic [NW_W-1:0]     seen_reg;
    logic [NW_W-1:0]     seen_next;
    logic [NW_W-1:0]     n_eff;
    logic [2:0]          len_wide;
    logic [LETTER_W-1:0] letter_c;
    logic [ADDR_W-1:0]   idx;

    // Out-of-range letters count as the last letter of the alphabet
    always_comb begin
        if ({1'b0, letter} >= (LETTER_PORT_W + 1)'(ALPHABET_SIZE)) begin
            letter_c = LETTER_W'(ALPHABET_SIZE - 1);
        end else begin
            letter_c = letter[LETTER_W-1:0];
        end
    end

    // Zero acts as one, beyond the maximum acts as the maximum
    always_comb begin
        len_wide = {1'b0, ngram_length};
        if (len_wide == 3'd0) begin
            n_eff = NW_W'(1);
        end else if (len_wide > 3'(MAX_WINDOW)) begin
            n_eff = NW_W'(MAX_WINDOW);
        end else begin
            n_eff = NW_W'(len_wide);
        end
    end

    assign seen_next = (seen_reg < NW_W'(MAX_WINDOW)) ? seen_reg + NW_W'(1) : seen_reg;
    assign win_score = (seen_next >= n_eff);

    // Oldest letter is the most significant digit
    always_comb begin
        idx = '0;
        for (int k = MAX_WINDOW - 2; k >= 0; k--) begin
            if (k <= int'(n_eff) - 2) begin
                idx = ADDR_W'(idx * RADIX) + ADDR_W'(hist_reg[k]);
            end
        end
        win_addr = ADDR_W'(idx * RADIX) + ADDR_W'(letter_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            for (int k = 0; k < HIST_D; k++) begin
                hist_reg[k] <= '0;
            end
        end else if (advance) begin
            if (end_of_text) begin
                seen_reg <= '0;
                for (int k = 0; k < HIST_D; k++) begin
                    hist_reg[k] <= '0;
                end
            end else begin
                seen_reg <= seen_next;
                for (int k = HIST_D - 1; k > 0; k--) begin
                    hist_reg[k] <= hist_reg[k-1];
                end
                hist_reg[0] <= letter_c;
            end
        end
    end

endmodule

// ===== src/ngls_accum.sv =====
// Saturating score sum and result register of the scorer.
module ngls_accum #(
    parameter int LOG_WIDTH = 16,
    parameter int SUM_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ngls_pkg::ngls_s2_ctrl_t            in_ctrl,
    output logic                               in_ready,
    input  logic                               rd_present,
    input  logic signed [LOG_WIDTH-1:0]        rd_log_prob,
    input  logic signed [LOG_WIDTH-1:0]        missing_log_prob,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ngls_pkg::SCORE_W-1:0]       m_tdata
);
    import ngls_pkg::*;

    localparam int WIDE_W = SUM_WIDTH + LOG_WIDTH + 1;
    localparam int HIGH_W = WIDE_W - SUM_WIDTH + 1;

    logic                        s2_valid_reg;
    logic                        s2_score_reg;
    logic                        s2_last_reg;
    logic signed [SUM_WIDTH-1:0] sum_reg;
    logic signed [SUM_WIDTH-1:0] sum_next;
    logic                        out_valid_reg;
    logic [SCORE_W-1:0]          out_data_reg;

    logic                        out_free;
    logic                        s2_go;
    logic signed [LOG_WIDTH-1:0] addend;
    logic [WIDE_W-1:0]           wide_sum;
    logic [HIGH_W-1:0]           high_bits;
    logic [SUM_WIDTH+SCORE_W-1:0] score_ext;

    assign out_free = !out_valid_reg || m_tready;
    assign s2_go    = s2_valid_reg && (!s2_last_reg || out_free);
    assign in_ready = !s2_valid_reg || s2_go;

    always_comb begin
        if (!s2_score_reg) begin
            addend = '0;
        end else if (rd_present) begin
            addend = rd_log_prob;
        end else begin
            addend = missing_log_prob;
        end
    end

    assign wide_sum  = {{(LOG_WIDTH + 1){sum_reg[SUM_WIDTH-1]}}, sum_reg}
                     + {{(SUM_WIDTH + 1){addend[LOG_WIDTH-1]}}, addend};
    assign high_bits = wide_sum[WIDE_W-1:SUM_WIDTH-1];

    // Clamp to the sum's range when the high bits disagree
    always_comb begin
        if ((&high_bits) || !(|high_bits)) begin
            sum_next = wide_sum[SUM_WIDTH-1:0];
        end else if (wide_sum[WIDE_W-1]) begin
            sum_next = {1'b1, {(SUM_WIDTH - 1){1'b0}}};
        end else begin
            sum_next = {1'b0, {(SUM_WIDTH - 1){1'b1}}};
        end
    end

    assign score_ext = {{SCORE_W{sum_next[SUM_WIDTH-1]}}, sum_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            s2_score_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                s2_valid_reg <= in_ctrl.valid;
                s2_score_reg <= in_ctrl.score;
                s2_last_reg  <= in_ctrl.last;
            end
            if (s2_go) begin
                sum_reg <= s2_last_reg ? '0 : sum_next;
            end
            if (s2_go && s2_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_go && s2_last_reg) begin
            out_data_reg <= score_ext[SCORE_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== src/ngram_log_probability_scorer_core.sv =====
// Top level of the n-gram log-probability scorer: input stage, config, table and sum.
//
// Streams text letters and table loads on one input channel (s_tuser = 1 for a letter,
// 0 for a load) and returns the Q21.10 log-likelihood of each text on m_tdata after
// the letter flagged with s_tlast. Every window of ngram_length letters addresses a
// table of ALPHABET_SIZE**MAX_WINDOW Q5.10 entries; windows without a present mark add
// missing_log_prob, and the sum saturates. One item is taken per clock while s_tready is
// high; it drops during the sweep and while a finished score waits on m_tready. The
// single table port serves either the load write or the window read of the item in the
// input register, and the read data feeds one add in the next stage. After reset the
// block sweeps the table clearing the present marks, one entry a cycle; s_tready stays
// low during the sweep while configuration writes are taken.
// Configuration must only be written while no item is in flight.
module ngram_log_probability_scorer_core #(
    parameter int MAX_WINDOW    = ngls_pkg::NGLS_MAX_WINDOW,
    parameter int ALPHABET_SIZE = ngls_pkg::NGLS_ALPHABET_SIZE,
    parameter int LOG_WIDTH     = ngls_pkg::NGLS_LOG_WIDTH,
    parameter int SUM_WIDTH     = ngls_pkg::NGLS_SUM_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [4:0] letter, [19:5] entry_index, [35:20] entry_log_prob,
    // [36] entry_present, [39:37] zero
    input  logic [ngls_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,   // [0] opcode
    input  logic                            s_tlast,   // end_of_text
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ngls_pkg::SCORE_W-1:0]    m_tdata,   // [31:0] score
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ngls_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ngls_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ngls_pkg::*;

    localparam int TABLE_DEPTH = ALPHABET_SIZE ** MAX_WINDOW;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int DATA_W      = LOG_WIDTH + 1;
    localparam int IDX_WIDE_W  = ADDR_W + INDEX_PORT_W;
    localparam int EXT_W       = LOG_PORT_W + LOG_WIDTH;

    // Configuration registers
    logic [NGRAM_LEN_W-1:0]  ngram_length_reg;
    logic [CFG_DATA_W-1:0]   missing_reg;

    // Input register
    logic                    s1_valid_reg;
    logic                    s1_op_reg;
    logic [LETTER_PORT_W-1:0] s1_letter_reg;
    logic                    s1_last_reg;
    logic [INDEX_PORT_W-1:0] s1_index_reg;
    logic [LOG_PORT_W-1:0]   s1_log_reg;
    logic                    s1_present_reg;

    // Table clearing sweep
    logic                    clear_busy_reg;
    logic [ADDR_W-1:0]       clear_addr_reg;

    logic                    s1_adv;
    logic                    s1_can;
    logic                    s2_ready;
    logic                    is_letter;
    logic                    load_in_range;
    logic [IDX_WIDE_W-1:0]   index_wide;
    logic [ADDR_W-1:0]       win_addr;
    logic                    win_score;
    logic                    tbl_wr_en;
    logic                    tbl_rd_en;
    logic [ADDR_W-1:0]       tbl_addr;
    logic [DATA_W-1:0]       tbl_wdata;
    logic [DATA_W-1:0]       tbl_rdata;
    logic [EXT_W-1:0]        entry_ext;
    logic [EXT_W-1:0]        missing_ext;
    ngls_s2_ctrl_t           s2_ctrl;

    // Configuration: always ready, last write wins
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ngram_length_reg <= NGRAM_LEN_W'(3);
            missing_reg      <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_NGRAM_LENGTH:     ngram_length_reg <= cfg_data[NGRAM_LEN_W-1:0];
                CFG_MISSING_LOG_PROB: missing_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: advance into the sum stage when it has room
    assign is_letter = (s1_op_reg == OP_LETTER);
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign s1_can    = !s1_valid_reg || s1_adv;
    assign s_tready  = s1_can && !clear_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_can) begin
            s1_valid_reg <= s_tvalid && !clear_busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_op_reg      <= s_tuser;
            s1_letter_reg  <= s_tdata[4:0];
            s1_index_reg   <= s_tdata[19:5];
            s1_log_reg     <= s_tdata[35:20];
            s1_present_reg <= s_tdata[36];
            s1_last_reg    <= s_tlast;
        end
    end

    // Sweep every table entry to absent after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clear_busy_reg) begin
            if (clear_addr_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                clear_busy_reg <= 1'b0;
            end else begin
                clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
            end
        end
    end

    // Loads beyond the table are dropped
    assign index_wide    = {{ADDR_W{1'b0}}, s1_index_reg};
    assign load_in_range = (index_wide < IDX_WIDE_W'(TABLE_DEPTH));

    // Resize the Q5.10 fields to the table's log width
    assign entry_ext   = {{LOG_WIDTH{s1_log_reg[LOG_PORT_W-1]}}, s1_log_reg};
    assign missing_ext = {{LOG_WIDTH{missing_reg[LOG_PORT_W-1]}}, missing_reg};

    ngls_window #(
        .MAX_WINDOW    (MAX_WINDOW),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ADDR_W        (ADDR_W)
    ) u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (s1_adv && is_letter),
        .letter       (s1_letter_reg),
        .end_of_text  (s1_last_reg),
        .ngram_length (ngram_length_reg),
        .win_addr     (win_addr),
        .win_score    (win_score)
    );

    // One table port: sweep write, load write or window read
    always_comb begin
        tbl_wr_en = 1'b0;
        tbl_rd_en = 1'b0;
        tbl_addr  = win_addr;
        tbl_wdata = {s1_present_reg, entry_ext[LOG_WIDTH-1:0]};
        if (clear_busy_reg) begin
            tbl_wr_en = 1'b1;
            tbl_addr  = clear_addr_reg;
            tbl_wdata = '0;
        end else if (s1_adv && !is_letter) begin
            tbl_wr_en = load_in_range;
            tbl_addr  = index_wide[ADDR_W-1:0];
        end else begin
            tbl_rd_en = s1_adv;
        end
    end

    ngls_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_table (
        .aclk  (aclk),
        .wr_en (tbl_wr_en),
        .rd_en (tbl_rd_en),
        .addr  (tbl_addr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    // Only letters reach the sum stage
    assign s2_ctrl.valid = s1_adv && is_letter;
    assign s2_ctrl.score = win_score;
    assign s2_ctrl.last  = s1_last_reg;

    ngls_accum #(
        .LOG_WIDTH (LOG_WIDTH),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_accum (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_ctrl          (s2_ctrl),
        .in_ready         (s2_ready),
        .rd_present       (tbl_rdata[DATA_W-1]),
        .rd_log_prob      (tbl_rdata[LOG_WIDTH-1:0]),
        .missing_log_prob (missing_ext[LOG_WIDTH-1:0]),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule

// ===== sim/ngls_score_checker.sv =====
// Score checker for the n-gram scorer: tracks table, history and sum, compares each score.
module ngls_score_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [ngls_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [ngls_pkg::SCORE_W-1:0]        m_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ngls_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ngls_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  mismatch_count,
    output int                                  scores_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ngls_pkg::*;

    localparam int TABLE_DEPTH = NGLS_ALPHABET_SIZE ** NGLS_MAX_WINDOW;
    localparam int INDEX_LSB   = LETTER_PORT_W;
    localparam int LOGP_LSB    = INDEX_LSB + INDEX_PORT_W;
    localparam int PRESENT_BIT = LOGP_LSB + LOG_PORT_W;
    localparam longint SUM_MAX = (longint'(1) << (NGLS_SUM_WIDTH - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    logic signed [LOG_PORT_W-1:0]    log_table [TABLE_DEPTH];
    bit                              entry_present [TABLE_DEPTH];
    logic [LETTER_PORT_W-1:0]        history [NGLS_MAX_WINDOW-1];   // [0] is the newest
    int                              text_letters;
    longint                          running_sum;
    logic [NGRAM_LEN_W-1:0]          window_len;
    logic signed [CFG_DATA_W-1:0]    absent_log_prob;
    logic [SCORE_W-1:0]              expected_scores [$];

    always @(posedge aclk) begin : track_scores
        logic [LETTER_PORT_W-1:0] letter;
        int                       span;
        int unsigned              addr;
        logic [SCORE_W-1:0]       expected;

        if (!aresetn) begin
            foreach (entry_present[i])
                entry_present[i] = 1'b0;
            foreach (history[i])
                history[i] = '0;
            text_letters    = 0;
            running_sum     = 0;
            window_len      = 2'd3;
            absent_log_prob = '0;
            expected_scores.delete();
            mismatch_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NGRAM_LENGTH: begin
                        window_len = cfg_data[NGRAM_LEN_W-1:0];
                    end
                    CFG_MISSING_LOG_PROB: begin
                        absent_log_prob = cfg_data;
                    end
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_LOAD) begin
                    addr = s_tdata[INDEX_LSB +: INDEX_PORT_W];
                    if (addr < TABLE_DEPTH) begin
                        log_table[addr]     = s_tdata[LOGP_LSB +: LOG_PORT_W];
                        entry_present[addr] = s_tdata[PRESENT_BIT];
                    end
                end else begin
                    letter = s_tdata[LETTER_PORT_W-1:0];
                    if (letter >= NGLS_ALPHABET_SIZE)
                        letter = LETTER_PORT_W'(NGLS_ALPHABET_SIZE - 1);
                    span = (window_len == 0) ? 1 : int'(window_len);
                    if (span > NGLS_MAX_WINDOW)
                        span = NGLS_MAX_WINDOW;
                    if (text_letters < NGLS_MAX_WINDOW)
                        text_letters++;

                    if (text_letters >= span) begin
                        // oldest letter is the most significant base-26 digit
                        addr = 0;
                        for (int k = span - 2; k >= 0; k--)
                            addr = addr * NGLS_ALPHABET_SIZE + history[k];
                        addr = addr * NGLS_ALPHABET_SIZE + letter;
                        if (entry_present[addr])
                            running_sum += longint'(log_table[addr]);
                        else
                            running_sum += longint'(absent_log_prob);
                        if (running_sum > SUM_MAX)
                            running_sum = SUM_MAX;
                        else if (running_sum < SUM_MIN)
                            running_sum = SUM_MIN;
                    end

                    for (int k = NGLS_MAX_WINDOW - 2; k > 0; k--)
                        history[k] = history[k-1];
                    history[0] = letter;

                    if (s_tlast) begin
                        expected_scores.push_back(running_sum[SCORE_W-1:0]);
                        foreach (history[i])
                            history[i] = '0;
                        text_letters = 0;
                        running_sum  = 0;
                    end
                end
            end

            if (m_tvalid && m_tready) begin
                if (expected_scores.size() == 0) begin
                    $display("%0t: unexpected score, expected none, actual %0d (0x%08h)",
                             $time, $signed(m_tdata), m_tdata);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    expected = expected_scores.pop_front();
                    if (m_tdata !== expected) begin
                        $display("%0t: score mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                                 $time, $signed(expected), expected, $signed(m_tdata), m_tdata);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
        scores_pending <= expected_scores.size();
    end

endmodule

// ===== sim/ngram_log_probability_scorer_core_tb.sv =====
// Testbench top of the n-gram scorer: clock, reset, stimulus, back-pressure and verdict.
module ngram_log_probability_scorer_core_tb ();
    timeunit 1ns;
    timeprecision 1ps;
    import ngls_pkg::*;

    localparam int DRAIN_CYCLES = 8;      // idle time after the last score is taken
    localparam int LONG_STALL   = 400;    // receiver hold-off under pressure
    localparam int PHASE_ITEMS  = 180;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]       s_tdata   = '0;
    logic                       s_tuser   = OP_LOAD;
    logic                       s_tlast   = 1'b0;
    logic                       m_tready  = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;
    wire                        s_tready;
    wire                        m_tvalid;
    wire  [SCORE_W-1:0]         m_tdata;
    wire                        cfg_ready;

    int mismatches;
    int scores_pending;
    int items_sent  = 0;
    int tx_idle_pct = 13;
    int rx_idle_pct = 67;
    bit stall_armed = 1'b0;
    bit stall_done  = 1'b0;
    int stall_left  = 0;

    ngram_log_probability_scorer_core i_dut (.*);

    ngls_score_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatches),
        .scores_pending (scores_pending)
    );

    always #5 aclk = ~aclk;

    // Result side: random back-pressure, plus one long hold-off once armed.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_armed && !stall_done) begin
            m_tready   <= 1'b0;
            stall_left <= LONG_STALL;
            stall_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one item, idling first at random, and hold it until the transfer.
    task automatic send_item(input logic op, input logic [LETTER_PORT_W-1:0] letter,
                             input logic eot, input logic [INDEX_PORT_W-1:0] entry,
                             input logic [LOG_PORT_W-1:0] log_prob, input logic present);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= eot;
        s_tdata  <= S_TDATA_W'({present, log_prob, entry, letter});
        do
            @(posedge aclk);
        while (!s_tready);
        items_sent++;
    endtask

    // Fields unused by the item kind carry random junk.
    task automatic send_letter(input logic [LETTER_PORT_W-1:0] letter, input logic eot);
        send_item(OP_LETTER, letter, eot, INDEX_PORT_W'($urandom), LOG_PORT_W'($urandom),
                  1'($urandom));
    endtask

    task automatic send_load(input logic [INDEX_PORT_W-1:0] entry,
                             input logic [LOG_PORT_W-1:0] log_prob, input logic present);
        send_item(OP_LOAD, LETTER_PORT_W'($urandom), 1'($urandom), entry, log_prob, present);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Length register with random junk above the two live bits.
    task automatic write_length(input logic [NGRAM_LEN_W-1:0] len);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[NGRAM_LEN_W-1:0] = len;
        write_reg(CFG_NGRAM_LENGTH, data);
    endtask

    // Drop valid, wait for every outstanding score, then let the pipeline drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (scores_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Favour a few letters so that loaded windows actually get hit.
    function automatic logic [LETTER_PORT_W-1:0] pick_letter();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return LETTER_PORT_W'($urandom_range(3));
        if (r < 56)
            return LETTER_PORT_W'($urandom_range(31, NGLS_ALPHABET_SIZE));
        return LETTER_PORT_W'($urandom_range(NGLS_ALPHABET_SIZE - 1));
    endfunction

    function automatic logic [INDEX_PORT_W-1:0] pick_entry();
        int unsigned addr;
        int          span;
        addr = 0;
        if ($urandom_range(99) < 60) begin
            span = $urandom_range(1, NGLS_MAX_WINDOW);
            repeat (span)
                addr = addr * NGLS_ALPHABET_SIZE
                     + ($urandom_range(3) != 0 ? $urandom_range(3)
                                               : $urandom_range(NGLS_ALPHABET_SIZE - 1));
            return INDEX_PORT_W'(addr);
        end
        return INDEX_PORT_W'($urandom);
    endfunction

    function automatic logic [LOG_PORT_W-1:0] pick_log_prob();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 16'h8000;
        if (r < 18)
            return 16'h0000;
        if (r < 24)
            return 16'h7FFF;
        if (r < 70)
            return LOG_PORT_W'(-$urandom_range(32768));
        return LOG_PORT_W'($urandom);
    endfunction

    task automatic send_text(input int letters, input bit close);
        for (int i = 0; i < letters; i++)
            send_letter(pick_letter(), close && (i == letters - 1));
    endtask

    task automatic run_phase(input logic [NGRAM_LEN_W-1:0] len, input logic [CFG_DATA_W-1:0] miss,
                             input int tx_pct, input int rx_pct, input bit pressure);
        int first_item;
        write_length(len);
        write_reg(CFG_MISSING_LOG_PROB, miss);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        first_item  = items_sent;
        if (pressure) begin
            // hold the result side off while short texts keep coming
            stall_armed <= 1'b1;
            repeat (40) send_text(3, 1'b1);
        end
        while (items_sent - first_item < PHASE_ITEMS) begin
            if ($urandom_range(99) < 30) begin
                repeat ($urandom_range(1, 4))
                    send_load(pick_entry(), pick_log_prob(), $urandom_range(99) < 80);
            end else if ($urandom_range(9) == 0) begin
                send_text($urandom_range(9, 14), 1'b1);
            end else begin
                send_text($urandom_range(1, 8), 1'b1);
            end
        end
        // sometimes leave a text open so the next length applies mid-text
        if ($urandom_range(1) != 0)
            send_text($urandom_range(1, 2), 1'b0);
        settle();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: table extremes, ignored loads, short texts, clamped letters.
        write_length(2'd3);
        write_reg(CFG_MISSING_LOG_PROB, -16'sd1024);
        send_load(15'd0, 16'h8000, 1'b1);                         // AAA at the low extreme
        send_load(INDEX_PORT_W'(NGLS_ALPHABET_SIZE ** 3 - 1), 16'h7FFF, 1'b1); // ZZZ, high
        send_load(INDEX_PORT_W'(NGLS_ALPHABET_SIZE ** 3), 16'hFFFB, 1'b1); // past the table
        send_load(15'h7FFF, 16'hFFFA, 1'b1);                      // top address: ignored
        send_load(15'd1, 16'h7FFF, 1'b1);                         // AAB, and B alone
        send_load(15'd5, 16'hFFF9, 1'b0);                         // written but absent
        send_letter(5'd0, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd0, 1'b1);
        send_letter(5'd25, 1'b1);                                 // shorter than the window
        send_letter(5'd31, 1'b0);                                 // out-of-range letters clamp to Z
        send_letter(5'd30, 1'b0);
        send_letter(5'd26, 1'b1);
        send_letter(5'd0, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd0, 1'b0);
        send_letter(5'd1, 1'b0);
        send_letter(5'd2, 1'b1);                                  // ABC is absent
        // open a text at length three, go on at length zero (taken as one), finish at length two
        send_letter(5'd1, 1'b0);
        send_letter(5'd2, 1'b0);
        settle();
        write_length(2'd0);
        send_letter(5'd5, 1'b0);
        send_letter(5'd1, 1'b0);
        settle();
        write_length(2'd2);
        send_letter(5'd0, 1'b1);                                  // window BA, built from history
        settle();

        // Random: receiver idles, then sender idles, then neither.
        run_phase(2'd3, 16'h8000, 13, 67, 1'b0);
        run_phase(2'd1, 16'h0000, 13, 67, 1'b0);
        run_phase(2'd2, 16'h7FFF, 67, 13, 1'b0);
        run_phase(2'd0, CFG_DATA_W'($urandom), 67, 13, 1'b0);
        run_phase(2'd3, CFG_DATA_W'(-$urandom_range(32768)), 0, 0, 1'b1);
        run_phase(2'd2, 16'hFFFF, 0, 0, 1'b0);

        if (mismatches == 0 && scores_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: fails the run if it has not finished in time.
    initial begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
